>>> src/ps2kd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2kd_pkg
// shared types and constants of the ps/2 set-2 key decoder
// ----------------------------------------------------------------------------
package ps2kd_pkg;

  // character ring size, one slot always kept free
  localparam int FifoDepth = 256;
  localparam int PtrW      = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;

  // translation tables: one ram, upper table in the top half
  localparam int TabIdxW  = 7;
  localparam int TabAddrW = TabIdxW + 1;
  localparam int TabDepth = 2 ** TabAddrW;
  localparam int CharW    = 8;

  // set-2 codes
  localparam logic [7:0] CodeExt    = 8'hE0;
  localparam logic [7:0] CodeBreak  = 8'hF0;
  localparam logic [7:0] CodeLshift = 8'h12;
  localparam logic [7:0] CodeRshift = 8'h59;
  localparam logic [7:0] CodeCaps   = 8'h58;

  // request codes
  localparam logic [1:0] ReqScan   = 2'd0;
  localparam logic [1:0] ReqPop    = 2'd1;
  localparam logic [1:0] ReqTwrite = 2'd2;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_POP,
    CMD_LOOKUP,
    CMD_TWRITE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic               tsel;
    logic [TabIdxW-1:0] tidx;
    logic [CharW-1:0]   tval;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_WAIT
  } bk_state_e;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    n = (p == PtrW'(FifoDepth - 1)) ? '0 : p + PtrW'(1);
    return n;
  endfunction

endpackage

>>> src/ps2kd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2kd_ram
// generic ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ps2kd_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ps2kd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2kd_front
// accepts requests, tracks prefix/shift/caps flags, emits commands
// ----------------------------------------------------------------------------
module ps2kd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [1:0]                    req_type_i,
  input  logic [7:0]                    scancode_i,
  input  logic                          table_select_i,
  input  logic [ps2kd_pkg::TabIdxW-1:0] table_index_i,
  input  logic [ps2kd_pkg::CharW-1:0]   table_value_i,
  output ps2kd_pkg::cmd_t               cmd_o
);

  logic brk_q, brk_d;
  logic ext_q, ext_d;
  logic shift_q, shift_d;
  logic caps_q, caps_d;
  logic is_shift;

  assign is_shift = (scancode_i == ps2kd_pkg::CodeLshift) ||
                    (scancode_i == ps2kd_pkg::CodeRshift);

  always_comb begin
    brk_d        = brk_q;
    ext_d        = ext_q;
    shift_d      = shift_q;
    caps_d       = caps_q;
    cmd_o.kind   = ps2kd_pkg::CMD_NONE;
    cmd_o.tsel   = table_select_i;
    cmd_o.tidx   = table_index_i;
    cmd_o.tval   = table_value_i;
    case (req_type_i)
      ps2kd_pkg::ReqScan: begin
        if (scancode_i == ps2kd_pkg::CodeExt) begin
          ext_d = 1'b1;
        end else if (scancode_i == ps2kd_pkg::CodeBreak) begin
          brk_d = 1'b1;
        end else if (brk_q) begin
          brk_d = 1'b0;
          ext_d = 1'b0;
          if (is_shift) begin
            shift_d = 1'b0;
          end
        end else if (is_shift) begin
          shift_d = 1'b1;
        end else if (scancode_i == ps2kd_pkg::CodeCaps) begin
          caps_d = ~caps_q;
        end else begin
          ext_d = 1'b0;
          if (!scancode_i[7]) begin
            cmd_o.kind = ps2kd_pkg::CMD_LOOKUP;
            cmd_o.tsel = shift_q ^ caps_q;
            cmd_o.tidx = scancode_i[ps2kd_pkg::TabIdxW-1:0];
          end
        end
      end
      ps2kd_pkg::ReqPop:    cmd_o.kind = ps2kd_pkg::CMD_POP;
      ps2kd_pkg::ReqTwrite: cmd_o.kind = ps2kd_pkg::CMD_TWRITE;
      default:              cmd_o.kind = ps2kd_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brk_q   <= 1'b0;
      ext_q   <= 1'b0;
      shift_q <= 1'b0;
      caps_q  <= 1'b0;
    end else if (accept_i) begin
      brk_q   <= brk_d;
      ext_q   <= ext_d;
      shift_q <= shift_d;
      caps_q  <= caps_d;
    end
  end

endmodule

>>> src/ps2kd_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2kd_cmd_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module ps2kd_cmd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            enq_i,
  input  ps2kd_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            deq_i,
  output logic            valid_o,
  output ps2kd_pkg::cmd_t cmd_o
);

  ps2kd_pkg::cmd_t slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = slot_q[rd_q];

  always_comb begin
    wr_d  = enq_i ? ~wr_q : wr_q;
    rd_d  = deq_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(enq_i) - 2'(deq_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

endmodule

>>> src/ps2kd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2kd_back
// executes commands against the tables and the character ring
// ----------------------------------------------------------------------------
module ps2kd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  ps2kd_pkg::cmd_t             cmd_i,
  output logic                        cmd_deq_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [ps2kd_pkg::CharW-1:0] popped_char_o,
  output logic                        pop_empty_o,
  output logic                        char_pushed_o,
  output logic                        char_dropped_o
);

  localparam int PtrW  = ps2kd_pkg::PtrW;
  localparam int CharW = ps2kd_pkg::CharW;
  localparam int AddrW = ps2kd_pkg::TabAddrW;

  ps2kd_pkg::bk_state_e state_q, state_d;
  ps2kd_pkg::cmd_kind_e kind_q, kind_d;
  logic [AddrW-1:0]     taddr_q, taddr_d;
  logic [ps2kd_pkg::TabDepth-1:0] tvalid_q, tvalid_d;
  logic [PtrW-1:0]      wp_q, wp_d, rp_q, rp_d;

  logic             out_valid_q, out_valid_d;
  logic [CharW-1:0] out_char_q, out_char_d;
  logic             out_empty_q, out_empty_d;
  logic             out_push_q, out_push_d;
  logic             out_drop_q, out_drop_d;
  logic             load;
  logic             out_free;

  logic             tab_we, tab_re;
  logic [AddrW-1:0] tab_addr_rd;
  logic [CharW-1:0] tab_rdata;
  logic             ring_we, ring_re;
  logic [CharW-1:0] ring_rdata;
  logic [CharW-1:0] ch;
  logic             ring_empty, ring_full;

  assign out_free   = !out_valid_q || pop_i;
  assign ring_empty = (wp_q == rp_q);
  assign ring_full  = (ps2kd_pkg::ptr_next(wp_q) == rp_q);
  assign ch         = tvalid_q[taddr_q] ? tab_rdata : '0;
  assign tab_addr_rd = {cmd_i.tsel, cmd_i.tidx};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ps2kd_pkg::BK_IDLE: begin
        if (cmd_valid_i && out_free) begin
          if (cmd_i.kind == ps2kd_pkg::CMD_LOOKUP ||
              (cmd_i.kind == ps2kd_pkg::CMD_POP && !ring_empty)) begin
            state_d = ps2kd_pkg::BK_WAIT;
          end
        end
      end
      ps2kd_pkg::BK_WAIT: state_d = ps2kd_pkg::BK_IDLE;
      default:            state_d = ps2kd_pkg::BK_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cmd_deq_o   = 1'b0;
    kind_d      = kind_q;
    taddr_d     = taddr_q;
    tvalid_d    = tvalid_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    tab_we      = 1'b0;
    tab_re      = 1'b0;
    ring_we     = 1'b0;
    ring_re     = 1'b0;
    load        = 1'b0;
    out_char_d  = '0;
    out_empty_d = 1'b0;
    out_push_d  = 1'b0;
    out_drop_d  = 1'b0;
    case (state_q)
      ps2kd_pkg::BK_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_deq_o = 1'b1;
          kind_d    = cmd_i.kind;
          taddr_d   = tab_addr_rd;
          case (cmd_i.kind)
            ps2kd_pkg::CMD_TWRITE: begin
              tab_we               = 1'b1;
              tvalid_d[tab_addr_rd] = 1'b1;
              load                 = 1'b1;
            end
            ps2kd_pkg::CMD_POP: begin
              if (ring_empty) begin
                load        = 1'b1;
                out_empty_d = 1'b1;
              end else begin
                ring_re = 1'b1;
              end
            end
            ps2kd_pkg::CMD_LOOKUP: tab_re = 1'b1;
            default:               load   = 1'b1;
          endcase
        end
      end
      ps2kd_pkg::BK_WAIT: begin
        load = 1'b1;
        if (kind_q == ps2kd_pkg::CMD_POP) begin
          out_char_d = ring_rdata;
          rp_d       = ps2kd_pkg::ptr_next(rp_q);
        end else if (ch != '0) begin
          if (ring_full) begin
            out_drop_d = 1'b1;
          end else begin
            ring_we    = 1'b1;
            wp_d       = ps2kd_pkg::ptr_next(wp_q);
            out_push_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = load || (out_valid_q && !pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ps2kd_pkg::BK_IDLE;
      kind_q      <= ps2kd_pkg::CMD_NONE;
      tvalid_q    <= '0;
      wp_q        <= '0;
      rp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      tvalid_q    <= tvalid_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    taddr_q <= taddr_d;
    if (load) begin
      out_char_q  <= out_char_d;
      out_empty_q <= out_empty_d;
      out_push_q  <= out_push_d;
      out_drop_q  <= out_drop_d;
    end
  end

  ps2kd_ram #(
    .Width (CharW),
    .Depth (ps2kd_pkg::TabDepth)
  ) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_addr_rd),
    .wdata_i (cmd_i.tval),
    .re_i    (tab_re),
    .raddr_i (tab_addr_rd),
    .rdata_o (tab_rdata)
  );

  ps2kd_ram #(
    .Width (CharW),
    .Depth (ps2kd_pkg::FifoDepth)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (wp_q),
    .wdata_i (ch),
    .re_i    (ring_re),
    .raddr_i (rp_q),
    .rdata_o (ring_rdata)
  );

  assign empty_o        = !out_valid_q;
  assign popped_char_o  = out_char_q;
  assign pop_empty_o    = out_empty_q;
  assign char_pushed_o  = out_push_q;
  assign char_dropped_o = out_drop_q;

endmodule

>>> src/ps2_set2_key_decoder_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_set2_key_decoder_fifo
// ps/2 set-2 scancode decoder with translation tables and a character ring
// ----------------------------------------------------------------------------
// Every request (scancode byte, character pop, table write) returns exactly
// one result transaction, in request order. Requests enter through push/full
// and are classified in the same cycle by the front end, which owns the
// break/extended/shift/caps flags, then wait in a two-entry command queue.
// The back end runs one command at a time: table writes, empty pops and
// bytes that decode to nothing load their result from idle; table lookups and pops
// of a buffered character first wait for the registered read of the
// table ram or the ring ram. Results sit in a one-entry output register;
// a new command starts in the cycle that register is popped. The ring keeps
// at most 255 characters (one slot stays free). Both tables read as zero
// after reset through per-entry valid flops, so there is no clearing pass
// and requests are taken right after reset.
// ----------------------------------------------------------------------------
module ps2_set2_key_decoder_fifo (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request side
  input  logic       push,
  output logic       full,
  input  logic [1:0] req_type_i,
  input  logic [7:0] scancode_i,
  input  logic       table_select_i,
  input  logic [6:0] table_index_i,
  input  logic [7:0] table_value_i,
  // result side
  output logic       empty,
  input  logic       pop,
  output logic [7:0] popped_char_o,
  output logic       pop_empty_o,
  output logic       char_pushed_o,
  output logic       char_dropped_o
);

  // front end to queue
  ps2kd_pkg::cmd_t front_cmd;
  logic            accept;

  // queue to back end
  ps2kd_pkg::cmd_t head_cmd;
  logic            cmd_valid;
  logic            cmd_deq;

  // a request transaction completes when the queue has room
  assign accept = push && !full;

  ps2kd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .req_type_i     (req_type_i),
    .scancode_i     (scancode_i),
    .table_select_i (table_select_i),
    .table_index_i  (table_index_i),
    .table_value_i  (table_value_i),
    .cmd_o          (front_cmd)
  );

  // decouples classification from execution
  ps2kd_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .enq_i   (accept),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .deq_i   (cmd_deq),
    .valid_o (cmd_valid),
    .cmd_o   (head_cmd)
  );

  // tables, ring and result register
  ps2kd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (head_cmd),
    .cmd_deq_o      (cmd_deq),
    .pop_i          (pop),
    .empty_o        (empty),
    .popped_char_o  (popped_char_o),
    .pop_empty_o    (pop_empty_o),
    .char_pushed_o  (char_pushed_o),
    .char_dropped_o (char_dropped_o)
  );

  // a full queue always has a command at its head
  assert property (@(posedge clk_i) disable iff (!rst_ni) full |-> cmd_valid)
    else $error("queue full without a head command");

  // the back end only takes a command that is there
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_deq |-> cmd_valid)
    else $error("dequeue from empty command queue");

  // a result carries at most one of its status flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ($countones({pop_empty_o, char_pushed_o, char_dropped_o}) <= 1))
    else $error("result with conflicting status flags");

  // a returned character never comes with a status flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && popped_char_o != 8'd0) |-> !(pop_empty_o || char_pushed_o || char_dropped_o))
    else $error("character returned with a status flag");

endmodule

>>> tb/tb_ps2_set2_key_decoder_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ps2_set2_key_decoder_fifo
// self-checking testbench for the ps/2 set-2 key decoder with character ring
// ----------------------------------------------------------------------------
// Requests (scancode bytes, character pops, table writes, unused codes) go in
// through push/full. A monitor on the request side feeds every accepted
// transaction to a behavioral decoder that keeps its own flags, tables and
// character ring, and queues the expected result. A checker on the result
// side compares every accepted result field by field against the oldest
// expectation. Directed tests cover prefixes, shift/caps and the table
// extremes. A ring test overflows the 255-character buffer, a backpressure
// test stalls the result side, and random key traffic follows.
// ----------------------------------------------------------------------------
module tb_ps2_set2_key_decoder_fifo;

  localparam int          ClkHalf       = 6;
  localparam int          ResetCycles   = 8;
  localparam int          HoldCycles    = 300;   // long receiver hold-off
  localparam int          StallLimit    = 2000;  // cycles with no transaction at all
  localparam int          DrainCycles   = 20;
  localparam int          RandomItems   = 200;
  localparam int          RingFillItems = 258;
  localparam logic [1:0]  ReqUnused     = 2'd3;
  localparam logic [7:0]  CodeMakeLimit = 8'h80;

  // one result transaction as seen on the result ports
  typedef struct packed {
    logic [7:0] ch;
    logic       was_empty;
    logic       pushed;
    logic       dropped;
  } key_result_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       push           = 1'b0;
  logic       full;
  logic [1:0] req_type_i     = '0;
  logic [7:0] scancode_i     = '0;
  logic       table_select_i = 1'b0;
  logic [6:0] table_index_i  = '0;
  logic [7:0] table_value_i  = '0;
  logic       empty;
  logic       pop            = 1'b0;
  logic [7:0] popped_char_o;
  logic       pop_empty_o;
  logic       char_pushed_o;
  logic       char_dropped_o;

  // decoder state mirrored by the testbench
  logic        brk_pend;
  logic        ext_pend;
  logic        shift_on;
  logic        caps_lock;
  logic [7:0]  lower_tab [128];
  logic [7:0]  upper_tab [128];
  logic [7:0]  char_q [$];
  key_result_t expected_q [$];

  // codes with a table entry written in the random phase
  logic [6:0]  mapped_codes [$];

  // stimulus shaping shared by the sender and the receiver
  bit no_idle  = 1'b0;
  bit hold_req = 1'b0;

  int items_sent   = 0;
  int n_results    = 0;
  int n_pushed     = 0;
  int n_dropped    = 0;
  int n_empty_pops = 0;
  int err_count    = 0;
  int stall_cycles = 0;

  ps2_set2_key_decoder_fifo u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .req_type_i     (req_type_i),
    .scancode_i     (scancode_i),
    .table_select_i (table_select_i),
    .table_index_i  (table_index_i),
    .table_value_i  (table_value_i),
    .empty          (empty),
    .pop            (pop),
    .popped_char_o  (popped_char_o),
    .pop_empty_o    (pop_empty_o),
    .char_pushed_o  (char_pushed_o),
    .char_dropped_o (char_dropped_o)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // behavioral decoder: applies one request and queues the expected result
  // --------------------------------------------------------------------------
  task decode_request(input logic [1:0] req, input logic [7:0] code, input logic tsel,
                      input logic [6:0] tidx, input logic [7:0] tval);
    key_result_t r;
    logic [7:0]  ch;
    logic        is_shift;
    r = '0;
    case (req)
      ps2kd_pkg::ReqScan: begin
        is_shift = (code == ps2kd_pkg::CodeLshift) || (code == ps2kd_pkg::CodeRshift);
        if (code == ps2kd_pkg::CodeExt) begin
          ext_pend = 1'b1;               // extended prefix, tracked only
        end else if (code == ps2kd_pkg::CodeBreak) begin
          brk_pend = 1'b1;
        end else if (brk_pend) begin
          // byte after a break: a key release, only shift cares
          brk_pend = 1'b0;
          ext_pend = 1'b0;
          if (is_shift) shift_on = 1'b0;
        end else if (is_shift) begin
          shift_on = 1'b1;
        end else if (code == ps2kd_pkg::CodeCaps) begin
          caps_lock = ~caps_lock;
        end else begin
          if (code < CodeMakeLimit) begin
            ch = (shift_on ^ caps_lock) ? upper_tab[code[6:0]] : lower_tab[code[6:0]];
            // zero translation: nothing pushed, nothing flagged
            if (ch != 8'h00) begin
              if (char_q.size() < ps2kd_pkg::FifoDepth - 1) begin
                char_q.push_back(ch);
                r.pushed = 1'b1;
                n_pushed++;
              end else begin
                // ring full: character lost
                r.dropped = 1'b1;
                n_dropped++;
              end
            end
          end
          ext_pend = 1'b0;
        end
      end
      ps2kd_pkg::ReqPop: begin
        if (char_q.size() != 0) begin
          r.ch = char_q.pop_front();
        end else begin
          r.was_empty = 1'b1;
          n_empty_pops++;
        end
      end
      ps2kd_pkg::ReqTwrite: begin
        if (tsel) upper_tab[tidx] = tval;
        else      lower_tab[tidx] = tval;
      end
      default: ;                         // unused request: all-zero result
    endcase
    expected_q.push_back(r);
  endtask

  initial begin
    brk_pend  = 1'b0;
    ext_pend  = 1'b0;
    shift_on  = 1'b0;
    caps_lock = 1'b0;
    for (int i = 0; i < 128; i++) begin
      lower_tab[i] = 8'h00;
      upper_tab[i] = 8'h00;
    end
  end

  // request monitor: values sampled before this edge's updates
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      decode_request(req_type_i, scancode_i, table_select_i, table_index_i, table_value_i);
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk_i) begin : check_results
    key_result_t want;
    if (rst_ni && pop && !empty) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: popped_char %0h", popped_char_o);
        err_count++;
      end else begin
        want = expected_q.pop_front();
        if (popped_char_o !== want.ch) begin
          $error("popped_char: expected %0h, got %0h", want.ch, popped_char_o);
          err_count++;
        end
        if (pop_empty_o !== want.was_empty) begin
          $error("pop_empty: expected %0b, got %0b", want.was_empty, pop_empty_o);
          err_count++;
        end
        if (char_pushed_o !== want.pushed) begin
          $error("char_pushed: expected %0b, got %0b", want.pushed, char_pushed_o);
          err_count++;
        end
        if (char_dropped_o !== want.dropped) begin
          $error("char_dropped: expected %0b, got %0b", want.dropped, char_dropped_o);
          err_count++;
        end
      end
    end
  end

  // watchdog: ends the run if no transaction moves on either side for too long
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: no transaction for %0d cycles", StallLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver: random pop, with a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      pop <= no_idle || ($urandom_range(99) >= 30);
    end
  end

  // --------------------------------------------------------------------------
  // sender: one request transaction, with an optional random gap before it;
  // push stays high after acceptance so back-to-back requests need no toggle
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] req, input logic [7:0] code, input logic tsel,
                           input logic [6:0] tidx, input logic [7:0] tval);
    int gap;
    if (!no_idle && $urandom_range(99) < 30) begin
      push <= 1'b0;
      gap = $urandom_range(3, 1);
      repeat (gap) @(posedge clk_i);
    end
    push           <= 1'b1;
    req_type_i     <= req;
    scancode_i     <= code;
    table_select_i <= tsel;
    table_index_i  <= tidx;
    table_value_i  <= tval;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
  endtask

  // unused fields get random values, the block must ignore them
  task automatic send_scan(input logic [7:0] code);
    send_item(ps2kd_pkg::ReqScan, code, 1'($urandom), 7'($urandom), 8'($urandom));
  endtask

  task automatic send_pop();
    send_item(ps2kd_pkg::ReqPop, 8'($urandom), 1'($urandom), 7'($urandom), 8'($urandom));
  endtask

  task automatic send_twrite(input logic tsel, input logic [6:0] tidx, input logic [7:0] tval);
    send_item(ps2kd_pkg::ReqTwrite, 8'($urandom), tsel, tidx, tval);
  endtask

  // one well-formed key gesture, or some noise now and then
  task automatic send_key_activity();
    int         pick;
    logic [7:0] code;
    logic [6:0] idx;
    pick = $urandom_range(99);
    if (mapped_codes.size() != 0 && $urandom_range(3) != 0) begin
      code = {1'b0, mapped_codes[$urandom_range(mapped_codes.size() - 1)]};
    end else begin
      code = 8'($urandom_range(127));
    end
    if (pick < 30) begin
      // key make, sometimes extended
      if ($urandom_range(4) == 0) send_scan(ps2kd_pkg::CodeExt);
      send_scan(code);
    end else if (pick < 45) begin
      // key release
      if ($urandom_range(4) == 0) send_scan(ps2kd_pkg::CodeExt);
      send_scan(ps2kd_pkg::CodeBreak);
      send_scan(code);
    end else if (pick < 55) begin
      code = $urandom_range(1) ? ps2kd_pkg::CodeLshift : ps2kd_pkg::CodeRshift;
      if ($urandom_range(1)) begin
        send_scan(code);
      end else begin
        send_scan(ps2kd_pkg::CodeBreak);
        send_scan(code);
      end
    end else if (pick < 60) begin
      if ($urandom_range(3) == 0) send_scan(ps2kd_pkg::CodeBreak);
      send_scan(ps2kd_pkg::CodeCaps);
    end else if (pick < 85) begin
      send_pop();
    end else if (pick < 92) begin
      idx = 7'($urandom);
      send_twrite(1'($urandom), idx, ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom));
      if (mapped_codes.size() < 64) mapped_codes.push_back(idx);
    end else if (pick < 97) begin
      send_scan(8'($urandom_range(255)));
    end else begin
      send_item(ReqUnused, 8'($urandom), 1'($urandom), 7'($urandom), 8'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // empty pop, unused request, cleared tables and table extremes
  task automatic test_empty_and_unused();
    send_pop();                              // nothing buffered yet
    send_item(ReqUnused, 8'hFF, 1'b1, 7'h7F, 8'hFF);
    send_scan(8'h1C);                        // tables still cleared
    send_twrite(1'b0, 7'h1C, 8'h61);
    send_twrite(1'b1, 7'h1C, 8'h41);
    send_twrite(1'b0, 7'h7F, 8'hFF);         // top index, all-ones value
    send_twrite(1'b1, 7'h00, 8'h80);         // bottom index
    send_twrite(1'b0, 7'h2A, 8'h00);         // explicit zero entry
  endtask

  // shift, caps, break and extended prefixes, codes above the table range
  task automatic test_shift_caps();
    send_scan(8'h1C);                        // lower table
    send_scan(ps2kd_pkg::CodeLshift);
    send_scan(8'h1C);                        // upper table while shift held
    send_scan(ps2kd_pkg::CodeBreak);
    send_scan(ps2kd_pkg::CodeLshift);
    send_scan(ps2kd_pkg::CodeRshift);
    send_scan(8'h1C);
    send_scan(ps2kd_pkg::CodeBreak);
    send_scan(ps2kd_pkg::CodeRshift);
    send_scan(ps2kd_pkg::CodeCaps);          // caps on
    send_scan(8'h1C);
    send_scan(ps2kd_pkg::CodeLshift);
    send_scan(8'h1C);                        // shift and caps cancel
    send_scan(8'h00);                        // lower entry 0 is zero
    send_scan(ps2kd_pkg::CodeBreak);
    send_scan(ps2kd_pkg::CodeLshift);
    send_scan(8'h00);                        // upper entry 0
    send_scan(ps2kd_pkg::CodeBreak);
    send_scan(ps2kd_pkg::CodeCaps);          // caps release does not toggle
    send_scan(ps2kd_pkg::CodeCaps);          // caps off
    send_scan(ps2kd_pkg::CodeExt);
    send_scan(8'h1C);                        // extended flag has no effect
    send_scan(ps2kd_pkg::CodeExt);
    send_scan(ps2kd_pkg::CodeBreak);
    send_scan(8'h1C);
    send_scan(8'h7F);                        // top table entry
    send_scan(8'h80);                        // at or above 0x80: no lookup
    send_scan(8'hFF);
    send_scan(8'h2A);                        // zero translation
    repeat (4) send_pop();
  endtask

  // overflow the ring, then drain it past empty
  task automatic test_ring_full();
    logic [6:0] codes [8];
    codes = '{7'h15, 7'h1D, 7'h24, 7'h2D, 7'h2C, 7'h35, 7'h3C, 7'h43};
    // both tables loaded so shift/caps state does not matter
    for (int i = 0; i < 8; i++) begin
      send_twrite(1'b0, codes[i], 8'h61 + 8'(i));
      send_twrite(1'b1, codes[i], 8'h41 + 8'(i));
    end
    send_scan(8'h00);                        // consumes a pending break, if any
    for (int i = 0; i < RingFillItems; i++) send_scan({1'b0, codes[i % 8]});
    repeat (RingFillItems + 2) send_pop();
  endtask

  // receiver holds off while the sender keeps offering, so push stalls on full
  task automatic test_backpressure();
    hold_req = 1'b1;
    no_idle  = 1'b1;
    repeat (12) send_key_activity();
    no_idle  = 1'b0;
  endtask

  // random key traffic over a randomly loaded table, middle third without idling
  task automatic test_random_traffic();
    int         start;
    logic [6:0] idx;
    repeat (40) begin
      idx = 7'($urandom);
      send_twrite(1'($urandom), idx, ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom));
      mapped_codes.push_back(idx);
    end
    start = items_sent;
    while (items_sent - start < RandomItems) begin
      no_idle = (items_sent - start > RandomItems / 3) &&
                (items_sent - start < 2 * RandomItems / 3);
      send_key_activity();
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_unused();
    test_shift_caps();
    test_ring_full();
    test_backpressure();
    test_random_traffic();

    push <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d requests and %0d results: %0d characters buffered, %0d dropped",
             items_sent, n_results, n_pushed, n_dropped);
    $display("%0d pops found the ring empty; shift, caps, prefixes and table writes exercised",
             n_empty_pops);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/ps2kd_pkg.sv
src/ps2kd_ram.sv
src/ps2kd_front.sv
src/ps2kd_cmd_queue.sv
src/ps2kd_back.sv
src/ps2_set2_key_decoder_fifo.sv
tb/tb_ps2_set2_key_decoder_fifo.sv
